// ----- sv/dpsg_pkg.sv -----
// package for the dual phase sine generator
// types and constants shared by the dpsg modules, and the sine table used by the back
// no dependencies
`default_nettype none

package dpsg_pkg;

  localparam int TABLE_LENGTH   = 128;
  localparam int DAC_FULL_SCALE = 4095;
  localparam int IDX_W          = $clog2(TABLE_LENGTH);
  localparam int POS_W          = 8;
  localparam int DAC_W          = 16;
  localparam int ELAPSED_W      = 16;
  localparam int ACC_W          = 32;
  localparam int PHASE_W        = 8;
  localparam int SAMPLE_W       = 16;
  localparam int PROD_W         = 32;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 40;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam logic [ACC_W-1:0] PERIOD_RESET = 32'd7812;

  typedef enum logic [1:0] {
    MODE_BOTH   = 2'd0,
    MODE_FIRST  = 2'd1,
    MODE_SECOND = 2'd2,
    MODE_PAUSE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_FIRST_AMP  = 3'd1,
    REG_SECOND_AMP = 3'd2,
    REG_FIRST_OFF  = 3'd3,
    REG_SECOND_OFF = 3'd4,
    REG_PHASE      = 3'd5,
    REG_PERIOD     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    mode_e             mode;
    logic [DAC_W-1:0]  first_amp;
    logic [DAC_W-1:0]  second_amp;
    logic [DAC_W-1:0]  first_off;
    logic [DAC_W-1:0]  second_off;
    logic [IDX_W-1:0]  phase_mod;
    logic [ACC_W-1:0]  period;
  } cfg_t;

  // one classified word between front and back
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             wr_first;
    logic             wr_second;
    logic             use_phase;
  } step_t;

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [TABLE_LENGTH];
  typedef logic [IDX_W-1:0] phase_tab_t [2**PHASE_W];

  localparam int QUARTER_WAVE [33] = '{
    0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
    12539, 14010, 15446, 16846, 18204, 19519, 20787, 22005,
    23170, 24279, 25329, 26319, 27245, 28105, 28898, 29621,
    30273, 30852, 31356, 31785, 32137, 32412, 32609, 32728,
    32767
  };

  function automatic int coarse_sine(int pos);
    int p;
    int quad;
    int r;
    int mag;
    p    = pos & 127;
    quad = p >> 5;
    r    = p & 31;
    mag  = ((quad & 1) != 0) ? QUARTER_WAVE[32 - r] : QUARTER_WAVE[r];
    return ((quad & 2) != 0) ? -mag : mag;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    int fine;
    int c;
    int frac;
    int s0;
    int s1;
    for (int k = 0; k < TABLE_LENGTH; k++) begin
      fine   = (k * 32768) / TABLE_LENGTH;
      c      = fine >> 8;
      frac   = fine & 255;
      s0     = coarse_sine(c);
      s1     = coarse_sine(c + 1);
      rom[k] = SAMPLE_W'(s0 + ((s1 - s0) * frac) / 256);
    end
    return rom;
  endfunction

  function automatic phase_tab_t build_phase_tab();
    phase_tab_t tab;
    for (int k = 0; k < 2**PHASE_W; k++) begin
      tab[k] = IDX_W'(k % TABLE_LENGTH);
    end
    return tab;
  endfunction

  localparam sine_rom_t  SINE_ROM  = build_sine_rom();
  localparam phase_tab_t PHASE_MOD = build_phase_tab();

endpackage

`default_nettype wire

// ----- sv/dual_phase_sine_generator_core.sv -----
// top level of the dual phase sine generator: config registers, front, queue, back
// depends on dpsg_pkg, dpsg_front, dpsg_fifo, dpsg_back
//
// channel  dir  handshake                  word
// s_axis   in   s_axis_tvalid/tready       tdata[15:0] elapsed_us, [16] dac_enable
// m_axis   out  m_axis_tvalid/tready       tdata[15:0] first_dac, [31:16] second_dac,
//                                          [39:32] table_position
// cfg      in   cfg_valid_i/cfg_ready_o    cfg_index_i register, cfg_data_i value
//
// one word per cycle in and out unless the queue is full or the output stalls
// the accumulator add and compare are combinational in the front; the queue then feeds the back
// the back runs sine lookup, 16x16 multiply and clamp as three register stages
// reset clears accumulator, index and dac registers; mode comes up paused
// a stalled output holds the back; the four word queue keeps the front taking input until it is full
`default_nettype none

module dual_phase_sine_generator_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [dpsg_pkg::IN_DATA_W-1:0]     s_axis_tdata, // elapsed_us, dac_enable
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [dpsg_pkg::OUT_DATA_W-1:0]         m_axis_tdata, // first_dac, second_dac, table_position
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [dpsg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [dpsg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  dpsg_pkg::cfg_t  cfg_q, cfg_d;
  logic            q_push, q_full, q_pop, q_empty;
  dpsg_pkg::step_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dpsg_pkg::REG_MODE:       cfg_d.mode       = dpsg_pkg::mode_e'(cfg_data_i[1:0]);
        dpsg_pkg::REG_FIRST_AMP:  cfg_d.first_amp  = cfg_data_i[dpsg_pkg::DAC_W-1:0];
        dpsg_pkg::REG_SECOND_AMP: cfg_d.second_amp = cfg_data_i[dpsg_pkg::DAC_W-1:0];
        dpsg_pkg::REG_FIRST_OFF:  cfg_d.first_off  = cfg_data_i[dpsg_pkg::DAC_W-1:0];
        dpsg_pkg::REG_SECOND_OFF: cfg_d.second_off = cfg_data_i[dpsg_pkg::DAC_W-1:0];
        dpsg_pkg::REG_PHASE:
          cfg_d.phase_mod = dpsg_pkg::PHASE_MOD[cfg_data_i[dpsg_pkg::PHASE_W-1:0]];
        dpsg_pkg::REG_PERIOD:     cfg_d.period     = cfg_data_i[dpsg_pkg::ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= dpsg_pkg::MODE_PAUSE;
      cfg_q.first_amp  <= '0;
      cfg_q.second_amp <= '0;
      cfg_q.first_off  <= '0;
      cfg_q.second_off <= '0;
      cfg_q.phase_mod  <= '0;
      cfg_q.period     <= dpsg_pkg::PERIOD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dpsg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  dpsg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  dpsg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- sv/dpsg_fifo.sv -----
// short queue of classified step words between front and back
// depends on dpsg_pkg
`default_nettype none

module dpsg_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dpsg_pkg::step_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output dpsg_pkg::step_t     data_o,
  output logic                empty_o
);

  dpsg_pkg::step_t mem_q [dpsg_pkg::FIFO_DEPTH];
  logic [dpsg_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [dpsg_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [dpsg_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == dpsg_pkg::FIFO_CNT_W'(dpsg_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == dpsg_pkg::FIFO_PTR_W'(dpsg_pkg::FIFO_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == dpsg_pkg::FIFO_PTR_W'(dpsg_pkg::FIFO_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && push_i)) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(empty_o && pop_i)) else $error("queue read while empty");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a word");

endmodule

`default_nettype wire

// ----- sv/dpsg_front.sv -----
// front end: time accumulator, table index and step classification
// depends on dpsg_pkg
`default_nettype none

module dpsg_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dpsg_pkg::cfg_t                    cfg_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [dpsg_pkg::IN_DATA_W-1:0]    s_axis_tdata, // elapsed_us, dac_enable
  input  wire logic                              q_full_i,
  output logic                                   q_push_o,
  output dpsg_pkg::step_t                        q_data_o
);

  logic [dpsg_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [dpsg_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [dpsg_pkg::ACC_W:0]   sum;
  logic [dpsg_pkg::ACC_W-1:0] sat;
  logic                       enable;
  logic                       step;

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && s_axis_tready;
  assign enable        = s_axis_tdata[dpsg_pkg::ELAPSED_W];

  always_comb begin
    sum  = {1'b0, acc_q} + (dpsg_pkg::ACC_W + 1)'(s_axis_tdata[dpsg_pkg::ELAPSED_W-1:0]);
    sat  = sum[dpsg_pkg::ACC_W] ? '1 : sum[dpsg_pkg::ACC_W-1:0];
    step = (cfg_i.mode != dpsg_pkg::MODE_PAUSE) && (sat > cfg_i.period);
    acc_d = acc_q;
    idx_d = idx_q;
    if (q_push_o) begin
      acc_d = step ? '0 : sat;
      if (step) begin
        idx_d = (idx_q == dpsg_pkg::IDX_W'(dpsg_pkg::TABLE_LENGTH - 1)) ? '0
                : idx_q + 1'b1;
      end
    end
    q_data_o.idx       = idx_d;
    q_data_o.wr_first  = step && enable && (cfg_i.mode != dpsg_pkg::MODE_SECOND);
    q_data_o.wr_second = step && enable && (cfg_i.mode != dpsg_pkg::MODE_FIRST);
    q_data_o.use_phase = (cfg_i.mode == dpsg_pkg::MODE_BOTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      idx_q <= '0;
    end else begin
      acc_q <= acc_d;
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dpsg_back.sv -----
// back end: sine lookup, scaling, clamping and the dac output registers
// depends on dpsg_pkg
`default_nettype none

module dpsg_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dpsg_pkg::cfg_t                    cfg_i,
  input  wire logic                              q_empty_i,
  input  wire dpsg_pkg::step_t                   q_data_i,
  output logic                                   q_pop_o,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [dpsg_pkg::OUT_DATA_W-1:0]        m_axis_tdata // first_dac, second_dac, table_position
);

  logic adv;

  logic                                 s1_valid_q;
  dpsg_pkg::step_t                      s1_ctrl_q;
  logic signed [dpsg_pkg::SAMPLE_W-1:0] s1_sine1_q, s1_sine2_q;

  logic                                 s2_valid_q;
  dpsg_pkg::step_t                      s2_ctrl_q;
  logic signed [dpsg_pkg::PROD_W-1:0]   s2_prod1_q, s2_prod2_q;

  logic                                 out_valid_q;
  logic [dpsg_pkg::DAC_W-1:0]           first_out_q, first_out_d;
  logic [dpsg_pkg::DAC_W-1:0]           second_out_q, second_out_d;
  logic [dpsg_pkg::IDX_W-1:0]           pos_q;

  logic [dpsg_pkg::IDX_W:0]             pos_sum;
  logic [dpsg_pkg::IDX_W-1:0]           pos2;
  logic signed [dpsg_pkg::SAMPLE_W-1:0] half1, half2;

  function automatic logic [dpsg_pkg::DAC_W-1:0] level(
    input logic signed [dpsg_pkg::PROD_W-1:0] prod,
    input logic [dpsg_pkg::DAC_W-1:0]         off
  );
    logic signed [dpsg_pkg::PROD_W-1:0] biased;
    logic signed [dpsg_pkg::DAC_W:0]    swing;
    logic signed [dpsg_pkg::DAC_W+1:0]  v;
    biased = prod[dpsg_pkg::PROD_W-1] ? prod + 32'sd32767 : prod;
    swing  = biased[dpsg_pkg::DAC_W+15:15];
    v      = $signed({2'b00, off}) + (dpsg_pkg::DAC_W + 2)'(swing);
    if (v < 0) begin
      return '0;
    end else if (v > (dpsg_pkg::DAC_W + 2)'(dpsg_pkg::DAC_FULL_SCALE)) begin
      return dpsg_pkg::DAC_W'(dpsg_pkg::DAC_FULL_SCALE);
    end else begin
      return v[dpsg_pkg::DAC_W-1:0];
    end
  endfunction

  assign adv           = !out_valid_q || m_axis_tready;
  assign q_pop_o       = adv && !q_empty_i;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {dpsg_pkg::POS_W'(pos_q), second_out_q, first_out_q};

  always_comb begin
    pos_sum = {1'b0, q_data_i.idx} + {1'b0, cfg_i.phase_mod};
    if (pos_sum >= (dpsg_pkg::IDX_W + 1)'(dpsg_pkg::TABLE_LENGTH)) begin
      pos_sum = pos_sum - (dpsg_pkg::IDX_W + 1)'(dpsg_pkg::TABLE_LENGTH);
    end
    pos2  = q_data_i.use_phase ? pos_sum[dpsg_pkg::IDX_W-1:0] : q_data_i.idx;
    half1 = $signed({1'b0, cfg_i.first_amp[dpsg_pkg::DAC_W-1:1]});
    half2 = $signed({1'b0, cfg_i.second_amp[dpsg_pkg::DAC_W-1:1]});
    first_out_d  = s2_ctrl_q.wr_first ? level(s2_prod1_q, cfg_i.first_off) : first_out_q;
    second_out_d = s2_ctrl_q.wr_second ? level(s2_prod2_q, cfg_i.second_off) : second_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      first_out_q  <= '0;
      second_out_q <= '0;
      pos_q        <= '0;
    end else if (adv) begin
      s1_valid_q  <= !q_empty_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        first_out_q  <= first_out_d;
        second_out_q <= second_out_d;
        pos_q        <= s2_ctrl_q.idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctrl_q  <= q_data_i;
      s1_sine1_q <= dpsg_pkg::SINE_ROM[q_data_i.idx];
      s1_sine2_q <= dpsg_pkg::SINE_ROM[pos2];
      s2_ctrl_q  <= s1_ctrl_q;
      s2_prod1_q <= half1 * s1_sine1_q;
      s2_prod2_q <= half2 * s1_sine2_q;
    end
  end

  a_first_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_out_q <= dpsg_pkg::DAC_W'(dpsg_pkg::DAC_FULL_SCALE))
    else $error("first dac above full scale");

  a_second_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_out_q <= dpsg_pkg::DAC_W'(dpsg_pkg::DAC_FULL_SCALE))
    else $error("second dac above full scale");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(first_out_q) && $stable(second_out_q) && $stable(pos_q)))
    else $error("dac state changed while output stalled");

endmodule

`default_nettype wire

// ----- dv/dpsg_dac_checker.sv -----
`timescale 1ns / 100ps
// checker for the dual phase sine generator: predicts every dac word and compares it
// depends on dpsg_pkg for register codes, modes, widths and table size

module dpsg_dac_checker
  import dpsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [IN_DATA_W-1:0]  s_data_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [OUT_DATA_W-1:0] m_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam int QWAVE [33] = '{
    0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
    12539, 14010, 15446, 16846, 18204, 19519, 20787, 22005,
    23170, 24279, 25329, 26319, 27245, 28105, 28898, 29621,
    30273, 30852, 31356, 31785, 32137, 32412, 32609, 32728,
    32767
  };

  typedef struct {
    logic [DAC_W-1:0] first_dac;
    logic [DAC_W-1:0] second_dac;
    logic [POS_W-1:0] position;
  } dac_word_t;

  mode_e            gen_mode;
  logic [DAC_W-1:0] amp_a, amp_b, off_a, off_b;
  logic [PHASE_W-1:0] lead;
  logic [ACC_W-1:0] period;
  logic [ACC_W-1:0] acc;
  logic [POS_W-1:0] pos;
  logic [DAC_W-1:0] lvl_a, lvl_b, dac_a, dac_b;
  dac_word_t        dac_q [$];

  // sine of a 128 point circle from the quarter wave, q1.15
  function automatic int circle_sine(int p);
    int q;
    int r;
    int mag;
    p   = p & 127;
    q   = p >> 5;
    r   = p & 31;
    mag = ((q & 1) != 0) ? QWAVE[32 - r] : QWAVE[r];
    return ((q & 2) != 0) ? -mag : mag;
  endfunction

  function automatic int rom_sample(int k);
    int fine;
    int s0;
    int s1;
    fine = ((k % TABLE_LENGTH) * 32768) / TABLE_LENGTH;
    s0   = circle_sine(fine >> 8);
    s1   = circle_sine((fine >> 8) + 1);
    return s0 + ((s1 - s0) * (fine & 255)) / 256;
  endfunction

  function automatic logic [DAC_W-1:0] dac_level(logic [DAC_W-1:0] amp,
                                                 logic [DAC_W-1:0] off, int k);
    int half;
    int v;
    half = int'(amp >> 1);
    v    = int'(off) + (half * rom_sample(k)) / 32768;
    if (v < 0) v = 0;
    if (v > DAC_FULL_SCALE) v = DAC_FULL_SCALE;
    return DAC_W'(v);
  endfunction

  task automatic take_tick(logic [ELAPSED_W-1:0] el, logic en);
    logic [ACC_W:0] sum;
    dac_word_t      w;
    sum = {1'b0, acc} + el;
    acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    if (gen_mode != MODE_PAUSE && acc > period) begin
      acc = '0;
      pos = POS_W'((int'(pos) + 1) % TABLE_LENGTH);
      if (gen_mode == MODE_BOTH || gen_mode == MODE_FIRST)
        lvl_a = dac_level(amp_a, off_a, int'(pos));
      if (gen_mode == MODE_BOTH)
        lvl_b = dac_level(amp_b, off_b, (int'(pos) + int'(lead)) % TABLE_LENGTH);
      if (gen_mode == MODE_SECOND)
        lvl_b = dac_level(amp_b, off_b, int'(pos));
      if (en) begin
        if (gen_mode != MODE_SECOND) dac_a = lvl_a;
        if (gen_mode != MODE_FIRST) dac_b = lvl_b;
      end
    end
    w.first_dac  = dac_a;
    w.second_dac = dac_b;
    w.position   = pos;
    dac_q.push_back(w);
  endtask

  task automatic check_field(string name, logic [DAC_W-1:0] exp_v, logic [DAC_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    dac_word_t w;
    if (!rst_ni) begin
      gen_mode = MODE_PAUSE;
      amp_a    = '0;
      amp_b    = '0;
      off_a    = '0;
      off_b    = '0;
      lead     = '0;
      period   = PERIOD_RESET;
      acc      = '0;
      pos      = '0;
      lvl_a    = '0;
      lvl_b    = '0;
      dac_a    = '0;
      dac_b    = '0;
      dac_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:       gen_mode = mode_e'(cfg_data_i[1:0]);
          REG_FIRST_AMP:  amp_a    = cfg_data_i[DAC_W-1:0];
          REG_SECOND_AMP: amp_b    = cfg_data_i[DAC_W-1:0];
          REG_FIRST_OFF:  off_a    = cfg_data_i[DAC_W-1:0];
          REG_SECOND_OFF: off_b    = cfg_data_i[DAC_W-1:0];
          REG_PHASE:      lead     = cfg_data_i[PHASE_W-1:0];
          REG_PERIOD:     period   = cfg_data_i[ACC_W-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i)
        take_tick(s_data_i[ELAPSED_W-1:0], s_data_i[ELAPSED_W]);
      if (m_valid_i && m_ready_i) begin
        if (dac_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected dac word expected none actual %h", $time, m_data_i);
        end else begin
          w = dac_q.pop_front();
          check_field("first_dac", w.first_dac, m_data_i[15:0]);
          check_field("second_dac", w.second_dac, m_data_i[31:16]);
          check_field("table_position", DAC_W'(w.position), DAC_W'(m_data_i[39:32]));
        end
      end
    end
    pending_o = dac_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top for dual_phase_sine_generator_core: clock, reset, stimulus and verdict
// depends on dpsg_pkg, the core and dpsg_dac_checker

module tb_top;
  import dpsg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int LIMIT     = 600000;
  localparam int GAP_MAX   = 18;
  localparam int LONG_HOLD = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // elapsed_us, dac_enable
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // first_dac, second_dac, table_position
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int   errors;
  int   pending;
  int   words_sent;
  int   cfg_writes;
  logic tx_burst;
  logic rx_burst;
  logic long_stall;

  dual_phase_sine_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  dpsg_dac_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("tb_top: errors");
    $finish;
  end

  // dac side ready, with random holds and one long hold on request
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_stall) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_stall = 1'b0;
      end
      hold = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (hold > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_tick(input logic [ELAPSED_W-1:0] el, input logic en);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - ELAPSED_W - 1){1'b0}}, en, el};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // stop sending and wait until every dac word has come back
  task automatic settle();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] keep;
    case (idx)
      REG_MODE: keep = 32'h3;
      REG_FIRST_AMP, REG_SECOND_AMP, REG_FIRST_OFF, REG_SECOND_OFF: keep = 32'hFFFF;
      REG_PHASE: keep = 32'hFF;
      default: keep = '1;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= ($urandom() & ~keep) | (val & keep);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [DAC_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DAC_W'($urandom_range(0, 4095));
      default: return DAC_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [ACC_W-1:0] pick_period();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ACC_W'($urandom_range(1, 64));
      2: return ACC_W'($urandom_range(100, 3000));
      3: return ACC_W'(65534);
      default: return ACC_W'($urandom_range(0, 20000));
    endcase
  endfunction

  function automatic mode_e pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return MODE_BOTH;
    if (r < 6) return MODE_FIRST;
    if (r < 8) return MODE_SECOND;
    return MODE_PAUSE;
  endfunction

  initial begin
    logic [ACC_W-1:0]     period_now;
    logic [ELAPSED_W-1:0] el;
    int                   el_hi;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    words_sent    = 0;
    cfg_writes    = 0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    long_stall    = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // paused after reset: time piles up, outputs stay at zero
    send_tick(16'h0000, 1'b0);
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'hAAAA, 1'b1);
    settle();
    write_reg(REG_SPARE, $urandom());
    write_reg(REG_MODE, MODE_BOTH);
    write_reg(REG_FIRST_AMP, 32'hFFFF);
    write_reg(REG_SECOND_AMP, 32'd4095);
    write_reg(REG_FIRST_OFF, 32'd2048);
    write_reg(REG_SECOND_OFF, 32'd0);
    write_reg(REG_PHASE, 32'd200);
    write_reg(REG_PERIOD, 32'd0);
    // zero period: leftover time steps once, then zero elapsed holds
    send_tick(16'h0000, 1'b1);
    send_tick(16'h0000, 1'b1);
    send_tick(16'h0001, 1'b0);
    send_tick(16'h0001, 1'b1);
    repeat (6) send_tick(16'h0001, 1'b1);
    settle();
    write_reg(REG_MODE, MODE_FIRST);
    write_reg(REG_PHASE, 32'd255);
    repeat (3) send_tick(16'h0001, 1'b1);
    settle();
    write_reg(REG_MODE, MODE_SECOND);
    write_reg(REG_SECOND_OFF, 32'hFFFF);
    repeat (3) send_tick(16'h0001, 1'b1);

    // long period while paused: time piles up without a step
    settle();
    write_reg(REG_MODE, MODE_PAUSE);
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (20) send_tick(16'hFFFF, 1'($urandom_range(0, 1)));
    settle();
    write_reg(REG_MODE, MODE_BOTH);
    send_tick(16'h0000, 1'b1);
    send_tick(16'hFFFF, 1'b1);
    settle();
    write_reg(REG_PERIOD, 32'hFFFF_FFFE);
    send_tick(16'h0000, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      write_reg(REG_MODE, pick_mode());
      if ($urandom_range(0, 1) != 0) write_reg(REG_FIRST_AMP, pick_count());
      if ($urandom_range(0, 1) != 0) write_reg(REG_SECOND_AMP, pick_count());
      if ($urandom_range(0, 1) != 0) write_reg(REG_FIRST_OFF, pick_count());
      if ($urandom_range(0, 1) != 0) write_reg(REG_SECOND_OFF, pick_count());
      if ($urandom_range(0, 1) != 0) write_reg(REG_PHASE, $urandom_range(0, 255));
      period_now = pick_period();
      write_reg(REG_PERIOD, period_now);
      el_hi    = (period_now > 30000) ? 65535 : int'(period_now) * 2 + 2;
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (ph == 3) begin
        long_stall = 1'b1;
        tx_burst   = 1'b1;
      end
      repeat (125) begin
        el = ($urandom_range(0, 15) == 0) ? '1 : ELAPSED_W'($urandom_range(0, el_hi));
        send_tick(el, $urandom_range(0, 3) != 0);
      end
    end

    settle();
    $display("run: %0d words in, %0d register writes", words_sent, cfg_writes);
    $display("run: all modes, clamping, phase wrap, zero period and long pauses hit");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/dpsg_pkg.sv
sv/dpsg_fifo.sv
sv/dpsg_front.sv
sv/dpsg_back.sv
sv/dual_phase_sine_generator_core.sv
dv/dpsg_dac_checker.sv
dv/tb_top.sv
